// ===== rtl/spd_pkg.sv =====
package spd_pkg;

   // framing bytes
   localparam logic [7:0] START_BYTE = 8'hAA;
   localparam logic [7:0] END_BYTE   = 8'h55;

   // parser phases
   localparam logic [3:0] PH_HUNT  = 4'd0;
   localparam logic [3:0] PH_CNT_H = 4'd1;
   localparam logic [3:0] PH_CNT_L = 4'd2;
   localparam logic [3:0] PH_DEP_L = 4'd8;
   localparam logic [3:0] PH_END   = 4'd9;

   // register indexes
   localparam logic [1:0] REG_SLOPE     = 2'd0;
   localparam logic [1:0] REG_INTERCEPT = 2'd1;
   localparam logic [1:0] REG_DEPTH_LIM = 2'd2;

   // field widths
   localparam int WORD_W  = 16;
   localparam int SLOPE_W = 24;
   localparam int ICPT_W  = 32;
   localparam int PROD_W  = WORD_W + SLOPE_W;
   localparam int FRAC_W  = 16;

   // register reset values
   localparam logic [SLOPE_W-1:0] SLOPE_RST     = 24'd2998446;
   localparam logic [ICPT_W-1:0]  ICPT_RST      = 32'd122697000;
   localparam logic [WORD_W-1:0]  DEPTH_LIM_RST = 16'd2000;

endpackage

// ===== rtl/spd_oxygen.sv =====
module spd_oxygen (
   input  logic                          clock,
   input  logic                          load,
   input  logic [spd_pkg::WORD_W-1:0]    count,
   input  logic [spd_pkg::SLOPE_W-1:0]   slope,
   input  logic [spd_pkg::ICPT_W-1:0]    intercept,
   output logic [spd_pkg::WORD_W-1:0]    oxygen
);

   localparam int PW = spd_pkg::PROD_W;

   logic [PW-1:0] prod_ff;
   logic [PW-1:0] prod_in;
   logic [PW:0]   diff;
   logic [PW-spd_pkg::FRAC_W-1:0] scaled;

   // product of count and slope, taken once the count word is complete
   assign prod_in = PW'({{spd_pkg::SLOPE_W{1'b0}}, count} * {{spd_pkg::WORD_W{1'b0}}, slope});

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   // subtract offset, clamp at zero, drop fraction, saturate
   assign diff   = {1'b0, prod_ff} - {{(PW + 1 - spd_pkg::ICPT_W){1'b0}}, intercept};
   assign scaled = diff[PW-1:spd_pkg::FRAC_W];

   always_comb begin
      if (prod_ff <= {{(PW - spd_pkg::ICPT_W){1'b0}}, intercept}) begin
         oxygen = '0;
      end else if (|scaled[PW-spd_pkg::FRAC_W-1:spd_pkg::WORD_W]) begin
         oxygen = '1;
      end else begin
         oxygen = scaled[spd_pkg::WORD_W-1:0];
      end
   end

endmodule

// ===== rtl/sensor_packet_deframer.sv =====
// Sensor packet deframer: takes one received byte per request and emits one
// result per good frame (0xAA, four big-endian 16-bit words, 0x55). A byte is
// taken every cycle unless the request side stalls; the result appears in the
// output register in the cycle after its end byte is taken. The request side
// stalls only in its end phase while a stalled result side holds the previous
// result. The oxygen product count*slope is formed in the bytes after the count
// word, so the end byte needs only the offset subtract and saturation.
// Registers: 0x0 oxygen_slope (24 bit), 0x4 oxygen_intercept, 0x8 depth_limit.
module sensor_packet_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_oxygen_count,
   output logic [15:0] rsp_oxygen_milli,
   output logic [15:0] rsp_pressure_tenths,
   output logic [15:0] rsp_temperature_hundredths,
   output logic [15:0] rsp_depth_cm,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [spd_pkg::SLOPE_W-1:0] slope_ff;
   logic [spd_pkg::ICPT_W-1:0]  icpt_ff;
   logic [spd_pkg::WORD_W-1:0]  dlim_ff;

   logic [3:0]  phase_ff;
   logic [3:0]  phase_in;
   logic [7:0]  high_ff;
   logic [15:0] word_ff [4];
   logic [15:0] word_in;
   logic [1:0]  slot;

   logic        rsp_valid_ff;
   logic [15:0] cnt_ff, oxy_ff, pres_ff, temp_ff, dep_ff;

   logic        req_take;
   logic        rsp_take;
   logic        frame_done;
   logic        cnt_load;
   logic        csr_wr;
   logic [15:0] oxygen;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         slope_ff <= spd_pkg::SLOPE_RST;
         icpt_ff  <= spd_pkg::ICPT_RST;
         dlim_ff  <= spd_pkg::DEPTH_LIM_RST;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            spd_pkg::REG_SLOPE:     slope_ff <= csr_pwdata[spd_pkg::SLOPE_W-1:0];
            spd_pkg::REG_INTERCEPT: icpt_ff  <= csr_pwdata;
            spd_pkg::REG_DEPTH_LIM: dlim_ff  <= csr_pwdata[spd_pkg::WORD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         spd_pkg::REG_SLOPE:     csr_prdata = {8'd0, slope_ff};
         spd_pkg::REG_INTERCEPT: csr_prdata = icpt_ff;
         spd_pkg::REG_DEPTH_LIM: csr_prdata = {16'd0, dlim_ff};
         default:                csr_prdata = '0;
      endcase
   end

   // handshakes
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign req_stall = (phase_ff == spd_pkg::PH_END) && rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   assign word_in    = {high_ff, req_rx_byte};
   assign slot       = 2'((phase_ff >> 1) - 4'd1);
   assign frame_done = req_take && (phase_ff == spd_pkg::PH_END)
                       && (req_rx_byte == spd_pkg::END_BYTE);
   assign cnt_load   = req_take && (phase_ff == spd_pkg::PH_CNT_L);

   // next parse phase
   always_comb begin
      phase_in = phase_ff;
      if (req_take) begin
         priority if (phase_ff == spd_pkg::PH_HUNT) begin
            if (req_rx_byte == spd_pkg::START_BYTE) phase_in = spd_pkg::PH_CNT_H;
         end else if (phase_ff >= spd_pkg::PH_CNT_H && phase_ff <= spd_pkg::PH_DEP_L) begin
            phase_in = phase_ff + 4'd1;
         end else begin
            phase_in = spd_pkg::PH_HUNT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= spd_pkg::PH_HUNT;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // byte and word holds
   always_ff @(posedge clock) begin
      if (req_take && phase_ff >= spd_pkg::PH_CNT_H && phase_ff <= spd_pkg::PH_DEP_L) begin
         if (phase_ff[0]) begin
            high_ff <= req_rx_byte;
         end else begin
            word_ff[slot] <= word_in;
         end
      end
   end

   spd_oxygen u_oxygen (
      .clock     (clock),
      .load      (cnt_load),
      .count     (word_in),
      .slope     (slope_ff),
      .intercept (icpt_ff),
      .oxygen    (oxygen)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (frame_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_done) begin
         cnt_ff  <= word_ff[0];
         oxy_ff  <= oxygen;
         pres_ff <= word_ff[1];
         temp_ff <= word_ff[2];
         dep_ff  <= (word_ff[3] > dlim_ff) ? 16'd0 : word_ff[3];
      end
   end

   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_oxygen_count           = cnt_ff;
   assign rsp_oxygen_milli           = oxy_ff;
   assign rsp_pressure_tenths        = pres_ff;
   assign rsp_temperature_hundredths = temp_ff;
   assign rsp_depth_cm               = dep_ff;

`ifndef SYNTH
   // back-pressure only ever holds the end byte
   a_stall_at_end: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (phase_ff == spd_pkg::PH_END))
      else $error("request stalled outside end phase");

   // a new result follows a taken end byte
   a_rsp_from_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_take && phase_ff == spd_pkg::PH_END
                                    && req_rx_byte == spd_pkg::END_BYTE))
      else $error("result without end byte");

   // parser phase never goes beyond the end phase
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= spd_pkg::PH_END)
      else $error("parse phase out of range");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   localparam int LONG_HOLD = 400;

   typedef struct packed {
      logic [spd_pkg::WORD_W-1:0] count;
      logic [spd_pkg::WORD_W-1:0] milli;
      logic [spd_pkg::WORD_W-1:0] pres;
      logic [spd_pkg::WORD_W-1:0] temp;
      logic [spd_pkg::WORD_W-1:0] depth;
   } reading_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_oxygen_count;
   logic [15:0] rsp_oxygen_milli;
   logic [15:0] rsp_pressure_tenths;
   logic [15:0] rsp_temperature_hundredths;
   logic [15:0] rsp_depth_cm;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // register shadows, changed only while the block is idle
   logic [spd_pkg::SLOPE_W-1:0] cfg_slope = spd_pkg::SLOPE_RST;
   logic [spd_pkg::ICPT_W-1:0]  cfg_icpt  = spd_pkg::ICPT_RST;
   logic [spd_pkg::WORD_W-1:0]  cfg_dlim  = spd_pkg::DEPTH_LIM_RST;

   // parser shadow
   logic [3:0]                 frame_phase;
   logic [7:0]                 hi_byte;
   logic [spd_pkg::WORD_W-1:0] words [4];

   logic [7:0]  pending_bytes [$];
   reading_type expected_readings [$];

   logic req_gaps_on   = 1'b1;
   logic rsp_stalls_on = 1'b1;
   int   gap_left      = 0;
   int   stall_left    = 0;
   int   hold_left     = 0;
   int   hold_requests = 0;
   int   hold_served   = 0;

   int fail_count      = 0;
   int csr_fail_count  = 0;
   int bytes_sent      = 0;
   int readings_seen   = 0;
   int dropped_frames  = 0;
   int req_stall_cycles = 0;

   sensor_packet_deframer i_dut (
      .clock                      (clock),
      .reset                      (reset),
      .req_valid                  (req_valid),
      .req_stall                  (req_stall),
      .req_rx_byte                (req_rx_byte),
      .rsp_valid                  (rsp_valid),
      .rsp_stall                  (rsp_stall),
      .rsp_oxygen_count           (rsp_oxygen_count),
      .rsp_oxygen_milli           (rsp_oxygen_milli),
      .rsp_pressure_tenths        (rsp_pressure_tenths),
      .rsp_temperature_hundredths (rsp_temperature_hundredths),
      .rsp_depth_cm               (rsp_depth_cm),
      .csr_psel                   (csr_psel),
      .csr_penable                (csr_penable),
      .csr_pwrite                 (csr_pwrite),
      .csr_paddr                  (csr_paddr),
      .csr_pwdata                 (csr_pwdata),
      .csr_prdata                 (csr_prdata),
      .csr_pready                 (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // oxygen: max(0, count*slope - intercept) >> 16, saturated
   function automatic logic [spd_pkg::WORD_W-1:0] oxygen_of(
         input logic [spd_pkg::WORD_W-1:0] cnt);
      logic [spd_pkg::PROD_W-1:0] prod;
      logic [spd_pkg::PROD_W-1:0] diff;
      prod = spd_pkg::PROD_W'(cnt) * spd_pkg::PROD_W'(cfg_slope);
      if (prod <= spd_pkg::PROD_W'(cfg_icpt)) return '0;
      diff = prod - spd_pkg::PROD_W'(cfg_icpt);
      if (diff[spd_pkg::PROD_W-1:spd_pkg::FRAC_W+spd_pkg::WORD_W] != '0) return '1;
      return diff[spd_pkg::FRAC_W +: spd_pkg::WORD_W];
   endfunction

   // advance the parser shadow by one accepted byte
   function void parse_byte(input logic [7:0] b);
      reading_type r;
      logic [1:0]  slot;
      if (frame_phase == spd_pkg::PH_HUNT) begin
         if (b == spd_pkg::START_BYTE) frame_phase = spd_pkg::PH_CNT_H;
      end else if (frame_phase >= spd_pkg::PH_CNT_H && frame_phase <= spd_pkg::PH_DEP_L) begin
         if (frame_phase[0]) begin
            hi_byte = b;
         end else begin
            slot = frame_phase[2:1] - 2'd1;
            words[slot] = {hi_byte, b};
         end
         frame_phase = frame_phase + 4'd1;
      end else if (frame_phase == spd_pkg::PH_END) begin
         frame_phase = spd_pkg::PH_HUNT;
         if (b == spd_pkg::END_BYTE) begin
            r.count = words[0];
            r.milli = oxygen_of(words[0]);
            r.pres  = words[1];
            r.temp  = words[2];
            r.depth = (words[3] > cfg_dlim) ? '0 : words[3];
            expected_readings.push_back(r);
         end else begin
            dropped_frames++;
         end
      end else begin
         frame_phase = spd_pkg::PH_HUNT;
      end
   endfunction

   function void check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!req_gaps_on || r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else if (!(req_valid && req_stall)) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (pending_bytes.size() > 0) begin
            req_valid   <= 1'b1;
            req_rx_byte <= pending_bytes.pop_front();
            gap_left    <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: checks results, predicts from accepted requests, drives stall
   always @(posedge clock) begin
      reading_type want;
      int          r;
      if (reset) begin
         frame_phase = spd_pkg::PH_HUNT;
         hi_byte     = '0;
         for (int i = 0; i < 4; i++) words[i] = '0;
         expected_readings.delete();
         rsp_stall  <= 1'b0;
         stall_left <= 0;
         hold_left  <= 0;
      end else begin
         // compare with the oldest expected reading
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               $error("reading with none expected: count %0d", rsp_oxygen_count);
               fail_count++;
            end else begin
               want = expected_readings.pop_front();
               readings_seen++;
               check_field("oxygen_count", want.count, rsp_oxygen_count);
               check_field("oxygen_milli", want.milli, rsp_oxygen_milli);
               check_field("pressure_tenths", want.pres, rsp_pressure_tenths);
               check_field("temperature_hundredths", want.temp,
                           rsp_temperature_hundredths);
               check_field("depth_cm", want.depth, rsp_depth_cm);
            end
         end

         // predict from the accepted request
         if (req_valid && !req_stall) begin
            bytes_sent++;
            parse_byte(req_rx_byte);
         end
         if (req_valid && req_stall) req_stall_cycles++;

         // result-side back-pressure
         r = $urandom_range(0, 99);
         if (hold_served != hold_requests) begin
            hold_served++;
            hold_left <= LONG_HOLD;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
         end else if (!rsp_stalls_on || r < 70) begin
            rsp_stall <= 1'b0;
         end else if (r < 95) begin
            stall_left <= $urandom_range(0, 3);
            rsp_stall  <= 1'b1;
         end else begin
            stall_left <= $urandom_range(10, 40);
            rsp_stall  <= 1'b1;
         end
      end
   end

   task automatic push_frame(input logic [15:0] cnt, input logic [15:0] pres,
                             input logic [15:0] temp, input logic [15:0] depth,
                             input logic [7:0] end_byte);
      pending_bytes.push_back(spd_pkg::START_BYTE);
      pending_bytes.push_back(cnt[15:8]);
      pending_bytes.push_back(cnt[7:0]);
      pending_bytes.push_back(pres[15:8]);
      pending_bytes.push_back(pres[7:0]);
      pending_bytes.push_back(temp[15:8]);
      pending_bytes.push_back(temp[7:0]);
      pending_bytes.push_back(depth[15:8]);
      pending_bytes.push_back(depth[7:0]);
      pending_bytes.push_back(end_byte);
   endtask

   // random counts, counts near the zero crossing and the saturation point of the oxygen curve, and the extremes
   function automatic logic [15:0] pick_count();
      longint unsigned zero_pt;
      longint unsigned sat_pt;
      longint unsigned c;
      int              r;
      r = $urandom_range(0, 3);
      zero_pt = (cfg_slope == '0) ? 0 : longint'(cfg_icpt) / longint'(cfg_slope);
      sat_pt  = (cfg_slope == '0) ? 65535 :
                (longint'(cfg_icpt) + 64'h1_0000_0000) / longint'(cfg_slope);
      case (r)
         0: c = $urandom_range(0, 65535);
         1: c = zero_pt + $urandom_range(0, 4);
         2: c = sat_pt + $urandom_range(0, 4);
         default: c = $urandom_range(0, 1) ? 65535 : 0;
      endcase
      if ((r == 1 || r == 2) && c >= 2) c = c - 2;
      if (c > 65535) c = 65535 - $urandom_range(0, 2);
      return c[15:0];
   endfunction

   function automatic logic [15:0] pick_depth();
      if ($urandom_range(0, 2) == 0)
         return cfg_dlim + 16'($urandom_range(0, 2)) - 16'd1;
      return 16'($urandom);
   endfunction

   // mostly good frames with random content, some broken frames and noise
   task automatic queue_random(input int n_items);
      int         done;
      int         r;
      int         k;
      logic [7:0] e;
      done = 0;
      while (done < n_items) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            push_frame(pick_count(), 16'($urandom), 16'($urandom), pick_depth(),
                       spd_pkg::END_BYTE);
            done += 10;
         end else if (r < 80) begin
            e = 8'($urandom);
            if (e == spd_pkg::END_BYTE) e = spd_pkg::START_BYTE;
            push_frame(pick_count(), 16'($urandom), 16'($urandom), pick_depth(), e);
            done += 10;
         end else if (r < 88) begin
            k = $urandom_range(1, 8);
            pending_bytes.push_back(spd_pkg::START_BYTE);
            repeat (k) pending_bytes.push_back(8'($urandom));
            done += k + 1;
         end else begin
            k = $urandom_range(1, 4);
            repeat (k) pending_bytes.push_back(8'($urandom));
            done += k;
         end
      end
   endtask

   // bring the parser back to hunting and wait until the block is idle
   task automatic settle();
      repeat (10) pending_bytes.push_back(8'h00);
      while (pending_bytes.size() != 0 || req_valid || expected_readings.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // write one register, read it back, update the shadow
   task automatic program_reg(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] mask;
      logic [31:0] got;
      case (idx)
         spd_pkg::REG_SLOPE:     mask = 32'h00FF_FFFF;
         spd_pkg::REG_DEPTH_LIM: mask = 32'h0000_FFFF;
         default:                mask = 32'hFFFF_FFFF;
      endcase
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value & mask;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if ((got & mask) !== (value & mask)) begin
         $error("register %0d readback: expected %0d, got %0d", idx, value & mask,
                got & mask);
         csr_fail_count++;
      end
      case (idx)
         spd_pkg::REG_SLOPE:     cfg_slope = value[spd_pkg::SLOPE_W-1:0];
         spd_pkg::REG_INTERCEPT: cfg_icpt  = value[spd_pkg::ICPT_W-1:0];
         default:                cfg_dlim  = value[spd_pkg::WORD_W-1:0];
      endcase
   endtask

   task automatic program_all(input logic [31:0] slope, input logic [31:0] icpt,
                              input logic [31:0] dlim);
      program_reg(spd_pkg::REG_SLOPE, slope);
      program_reg(spd_pkg::REG_INTERCEPT, icpt);
      program_reg(spd_pkg::REG_DEPTH_LIM, dlim);
   endtask

   // main sequence
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: saturated oxygen and depth over the limit,
      // then a frame with a bad end byte of 0xAA that must not start a frame
      push_frame(16'hFFFF, 16'h0000, 16'hFFFF, spd_pkg::DEPTH_LIM_RST + 16'd1,
                 spd_pkg::END_BYTE);
      push_frame(16'h0000, 16'h1234, 16'h5678, spd_pkg::DEPTH_LIM_RST,
                 spd_pkg::START_BYTE);
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'h10);
      pending_bytes.push_back(8'h22);
      pending_bytes.push_back(8'h33);
      pending_bytes.push_back(8'h44);
      pending_bytes.push_back(8'h55);
      pending_bytes.push_back(8'h07);
      pending_bytes.push_back(8'hD0);
      pending_bytes.push_back(spd_pkg::END_BYTE);
      queue_random(150);
      settle();

      // full slope, no offset, widest depth limit; no idling on either side
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      program_all(32'h00FF_FFFF, 32'h0, 32'h0000_FFFF);
      push_frame(16'h0001, 16'hFFFF, 16'h0000, 16'hFFFF, spd_pkg::END_BYTE);
      queue_random(120);
      settle();

      // zero slope, largest offset, depth limit zero
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      program_all(32'h0, 32'hFFFF_FFFF, 32'h0);
      push_frame(16'hFFFF, 16'h8001, 16'h7FFE, 16'h0000, spd_pkg::END_BYTE);
      queue_random(80);
      settle();

      // random settings, with a long result-side hold while requests keep coming
      program_all($urandom_range(1, 24'hFF_FFFF), $urandom, $urandom_range(0, 65535));
      queue_random(200);
      hold_requests++;
      settle();

      // random settings with moderate slopes
      program_all($urandom_range(16'h100, 24'h0F_FFFF), $urandom_range(0, 32'h0FFF_FFFF),
                  $urandom_range(0, 65535));
      queue_random(200);
      settle();

      repeat (10) @(posedge clock);
      $display("run: %0d bytes sent, %0d readings checked, %0d frames dropped on a bad end",
               bytes_sent, readings_seen, dropped_frames);
      $display("run: 5 register settings, input back-pressure held for %0d cycles",
               req_stall_cycles);
      if (fail_count == 0 && csr_fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #1_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/spd_pkg.sv
rtl/spd_oxygen.sv
rtl/sensor_packet_deframer.sv
verif/testbench.sv
